>>> rtl/qrs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_pkg
// Shared types, widths and codes for the quadratic root solver.
// ---------------------------------------------------------------------------
package qrs_pkg;

    localparam int CoefW   = 16;
    localparam int RootW   = 34;
    localparam int DiscW   = 34;
    localparam int NbW     = 33;
    localparam int DenW    = 17;
    localparam int SqrtW   = 33;
    localparam int SqRemW  = 34;
    localparam int SqSteps = 33;
    localparam int DivW    = 34;
    localparam int DivRemW = 17;
    localparam int FifoDepthDef = 4;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_ONE   = 2'd1,
        ST_TWO   = 2'd2,
        ST_AZERO = 2'd3
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic signed [DenW-1:0]  den;
        logic signed [NbW-1:0]   nb;
        logic [DiscW-1:0]        disc;
    } t_entry;

    typedef struct packed {
        logic push;
        logic full;
    } t_front_ctl;

endpackage
`default_nettype wire

>>> rtl/qrs_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_fifo
// Small register queue between the classifying front and the solving back.
// ---------------------------------------------------------------------------
module qrs_fifo #(
    parameter int DEPTH = qrs_pkg::FifoDepthDef
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  qrs_pkg::t_front_ctl i_ctl,
    input  qrs_pkg::t_entry     i_entry,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_empty,
    output qrs_pkg::t_entry     o_entry
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    qrs_pkg::t_entry r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            push, pop;

    assign push    = i_ctl.push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push && i_ctl.full |-> !push)
        else $error("push into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(DEPTH))
        else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count lost a push");

endmodule
`default_nettype wire

>>> rtl/qrs_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_front
// Accepts coefficient beats, forms the discriminant and classifies them.
// ---------------------------------------------------------------------------
module qrs_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire signed [15:0]         i_coef_a,
    input  wire signed [15:0]         i_coef_b,
    input  wire signed [15:0]         i_coef_c,
    input  wire                       i_full,
    output qrs_pkg::t_front_ctl       o_ctl,
    output qrs_pkg::t_entry           o_entry
);

    logic               en;
    logic               r_v1, r_v2;
    logic signed [15:0] r_a, r_b;
    logic signed [31:0] r_bb, r_ac;
    logic signed [34:0] n_disc;
    qrs_pkg::t_entry    n_entry, r_entry;

    assign en      = !(r_v2 && i_full);
    assign o_stall = !en;

    always_comb begin
        n_disc        = 35'(r_bb) - (35'(r_ac) <<< 2);
        n_entry.den   = {r_a, 1'b0};
        n_entry.nb    = -{r_b[15], r_b, 16'h0000};
        n_entry.disc  = n_disc[34] ? '0 : n_disc[33:0];
        if (r_a == '0) begin
            n_entry.status = qrs_pkg::ST_AZERO;
        end else if (n_disc[34]) begin
            n_entry.status = qrs_pkg::ST_NONE;
        end else if (n_disc == '0) begin
            n_entry.status = qrs_pkg::ST_ONE;
        end else begin
            n_entry.status = qrs_pkg::ST_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= i_coef_a;
            r_b     <= i_coef_b;
            r_bb    <= i_coef_b * i_coef_b;
            r_ac    <= i_coef_a * i_coef_c;
            r_entry <= n_entry;
        end
    end

    assign o_ctl.push = r_v2;
    assign o_ctl.full = i_full;
    assign o_entry    = r_entry;

endmodule
`default_nettype wire

>>> rtl/qrs_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_back
// Pipelined square root and two restoring dividers producing both roots.
// ---------------------------------------------------------------------------
module qrs_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_empty,
    input  qrs_pkg::t_entry             i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [1:0]                  o_root_status,
    output logic signed [33:0]          o_root_plus,
    output logic signed [33:0]          o_root_minus
);

    localparam int NS = qrs_pkg::SqSteps;
    localparam int ND = qrs_pkg::DivW;

    logic en;

    // square root pipeline
    logic                                r_sv   [NS+1];
    qrs_pkg::t_entry                     r_se   [NS+1];
    logic [qrs_pkg::SqRemW-1:0]          r_srem [NS+1];
    logic [qrs_pkg::SqrtW-1:0]           r_sroot[NS+1];

    // divider pipeline
    logic                                r_dv   [ND+1];
    qrs_pkg::t_status                    r_dst  [ND+1];
    logic [qrs_pkg::DenW-1:0]            r_dm   [ND+1];
    logic                                r_pneg [ND+1];
    logic                                r_mneg [ND+1];
    logic [ND-1:0]                       r_pq   [ND+1];
    logic [ND-1:0]                       r_mq   [ND+1];
    logic [qrs_pkg::DivRemW-1:0]         r_pr   [ND+1];
    logic [qrs_pkg::DivRemW-1:0]         r_mr   [ND+1];

    logic                                r_ov;
    qrs_pkg::t_status                    r_ost;
    logic signed [33:0]                  r_op, r_om;

    assign en    = !(r_ov && i_stall);
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_se[0]    <= i_entry;
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_sqrt
        logic [1:0]                    pair;
        logic [qrs_pkg::SqRemW+1:0]    rs, trial, diff;
        logic                          ge;

        if (i < 17) begin : g_pair
            assign pair = r_se[i].disc[2*(16-i)+1 -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        always_comb begin
            rs    = {r_srem[i], pair};
            trial = {1'b0, r_sroot[i], 2'b01};
            ge    = (rs >= trial);
            diff  = rs - trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i+1] <= 1'b0;
            end else if (en) begin
                r_sv[i+1] <= r_sv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_se[i+1]    <= r_se[i];
                r_srem[i+1]  <= ge ? diff[qrs_pkg::SqRemW-1:0] : rs[qrs_pkg::SqRemW-1:0];
                r_sroot[i+1] <= {r_sroot[i][qrs_pkg::SqrtW-2:0], ge};
            end
        end
    end

    // numerators and magnitudes
    logic signed [34:0] np, nm;
    logic [33:0]        npm, nmm;
    logic signed [16:0] den;

    always_comb begin
        den = r_se[NS].den;
        np  = 35'(r_se[NS].nb) + $signed({2'b00, r_sroot[NS]});
        nm  = 35'(r_se[NS].nb) - $signed({2'b00, r_sroot[NS]});
        npm = np[34] ? 34'(-np) : np[33:0];
        nmm = nm[34] ? 34'(-nm) : nm[33:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_sv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dst[0]  <= r_se[NS].status;
            r_dm[0]   <= den[16] ? 17'(-den) : 17'(den);
            r_pneg[0] <= np[34] ^ den[16];
            r_mneg[0] <= nm[34] ^ den[16];
            r_pq[0]   <= npm;
            r_mq[0]   <= nmm;
            r_pr[0]   <= '0;
            r_mr[0]   <= '0;
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        logic [qrs_pkg::DivRemW:0] prr, mrr, pd, md;
        logic                      pge, mge;

        always_comb begin
            prr = {r_pr[k], r_pq[k][ND-1]};
            mrr = {r_mr[k], r_mq[k][ND-1]};
            pge = (prr >= {1'b0, r_dm[k]});
            mge = (mrr >= {1'b0, r_dm[k]});
            pd  = prr - {1'b0, r_dm[k]};
            md  = mrr - {1'b0, r_dm[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dst[k+1]  <= r_dst[k];
                r_dm[k+1]   <= r_dm[k];
                r_pneg[k+1] <= r_pneg[k];
                r_mneg[k+1] <= r_mneg[k];
                r_pq[k+1]   <= {r_pq[k][ND-2:0], pge};
                r_mq[k+1]   <= {r_mq[k][ND-2:0], mge};
                r_pr[k+1]   <= pge ? pd[qrs_pkg::DivRemW-1:0] : prr[qrs_pkg::DivRemW-1:0];
                r_mr[k+1]   <= mge ? md[qrs_pkg::DivRemW-1:0] : mrr[qrs_pkg::DivRemW-1:0];
            end
        end
    end

    // output register
    logic signed [33:0] n_op, n_om;
    logic               zero_out;

    always_comb begin
        zero_out = (r_dst[ND] == qrs_pkg::ST_NONE) || (r_dst[ND] == qrs_pkg::ST_AZERO);
        n_op = r_pneg[ND] ? -$signed(r_pq[ND]) : $signed(r_pq[ND]);
        n_om = r_mneg[ND] ? -$signed(r_mq[ND]) : $signed(r_mq[ND]);
        if (zero_out) begin
            n_op = '0;
            n_om = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ost <= r_dst[ND];
            r_op  <= n_op;
            r_om  <= n_om;
        end
    end

    assign o_valid       = r_ov;
    assign o_root_status = r_ost;
    assign o_root_plus   = r_op;
    assign o_root_minus  = r_om;

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_ost == qrs_pkg::ST_NONE || r_ost == qrs_pkg::ST_AZERO)
        |-> r_op == '0 && r_om == '0)
        else $error("roots not cleared");
    a_one_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ost == qrs_pkg::ST_ONE |-> r_op == r_om)
        else $error("single root differs");
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_ost) && $stable(r_op) && $stable(r_om))
        else $error("stalled beat changed");

endmodule
`default_nettype wire

>>> rtl/quadratic_root_solver.sv
`default_nettype none
// ---------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2+b*x+c in signed Q17.16, one coefficient set per beat.
// ---------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  coef      in    i_valid / o_stall    i_coef_a, i_coef_b, i_coef_c
//  root      out   o_valid / i_stall    o_root_status, o_root_plus, o_root_minus
//
//  one beat per cycle sustained while i_stall is low; path: 2 front stages,
//  queue, back input register, 33 square root steps, one numerator stage,
//  34 divider steps, output register. Both chains are fully pipelined.
//  reset is synchronous and clears only valid bits and the queue pointers and count.
//  output stall freezes the back while a root beat is held; the queue lets the front keep taking beats until it fills.
// ---------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int FIFO_DEPTH = qrs_pkg::FifoDepthDef
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire signed [15:0]   i_coef_a,
    input  wire signed [15:0]   i_coef_b,
    input  wire signed [15:0]   i_coef_c,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [1:0]          o_root_status,
    output logic signed [33:0]  o_root_plus,
    output logic signed [33:0]  o_root_minus
);

    qrs_pkg::t_front_ctl ctl;
    qrs_pkg::t_entry     f_entry, q_entry;
    logic                full, empty, pop;

    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .i_full   (full),
        .o_ctl    (ctl),
        .o_entry  (f_entry)
    );

    qrs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (q_entry)
    );

    qrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_root_status (o_root_status),
        .o_root_plus   (o_root_plus),
        .o_root_minus  (o_root_minus)
    );

endmodule
`default_nettype wire

>>> verif/tb_quadratic_root_solver.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_quadratic_root_solver
// Self-checking bench for the quadratic root solver: a directed table of
// coefficient sets, then random sets, each checked against table values or a behavioral
// model of the discriminant, square root and divide, with random idling
// on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_quadratic_root_solver;

    localparam int NDIR = 20;
    localparam int NRAND = 650;
    localparam int LAT = 80;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [33:0] plus;
        logic signed [33:0] minus;
    } t_roots;

    typedef struct {
        logic signed [15:0] a, b, c;
        logic               known;
        t_roots             res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_coef_a = '0;
    logic signed [15:0] i_coef_b = '0;
    logic signed [15:0] i_coef_c = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_root_status;
    logic signed [33:0] o_root_plus;
    logic signed [33:0] o_root_minus;

    t_roots expected_roots[$];
    t_row   dir_rows[NDIR];
    int     mismatches = 0;
    int     beats_out = 0;
    int     send_idle_pct = 15;
    int     recv_idle_pct = 65;
    bit     hold_off = 1'b0;
    int     n_status[4] = '{0, 0, 0, 0};

    quadratic_root_solver dut (.*);

    always #6 i_clk = ~i_clk;

    // integer square root of d * 2^32, d nonnegative
    function automatic logic [32:0] sqrt_q16(input logic [33:0] d);
        logic [67:0] x;
        logic [67:0] r;
        logic [67:0] bitv;
        x = {d, 32'd0};
        r = '0;
        bitv = 68'd1 << 66;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r[32:0];
    endfunction

    function automatic t_roots solve_roots(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic signed [15:0] c);
        t_roots r;
        longint d, den, nb, s;
        r = '0;
        if (a == 0) begin
            r.status = qrs_pkg::ST_AZERO;
        end else begin
            d = longint'(b) * b - 4 * longint'(a) * c;
            den = 2 * longint'(a);
            nb = -longint'(b) * 65536;
            if (d < 0) begin
                r.status = qrs_pkg::ST_NONE;
            end else if (d == 0) begin
                r.status = qrs_pkg::ST_ONE;
                r.plus = 34'(nb / den);
                r.minus = r.plus;
            end else begin
                s = longint'({31'd0, sqrt_q16(34'(d))});
                r.status = qrs_pkg::ST_TWO;
                r.plus = 34'((nb + s) / den);
                r.minus = 34'((nb - s) / den);
            end
        end
        return r;
    endfunction

    function automatic t_row mk(input int a, input int b, input int c, input bit known,
                                input logic [1:0] st, input longint p, input longint m);
        t_row r;
        r.a = 16'(a); r.b = 16'(b); r.c = 16'(c); r.known = known;
        r.res.status = st; r.res.plus = 34'(p); r.res.minus = 34'(m);
        return r;
    endfunction

    initial begin
        dir_rows[0]  = mk(0, 0, 0, 1, qrs_pkg::ST_AZERO, 0, 0);
        dir_rows[1]  = mk(0, 32767, -32768, 1, qrs_pkg::ST_AZERO, 0, 0);
        dir_rows[2]  = mk(0, -32768, 32767, 1, qrs_pkg::ST_AZERO, 0, 0);
        dir_rows[3]  = mk(1, 0, 1, 1, qrs_pkg::ST_NONE, 0, 0);
        dir_rows[4]  = mk(32767, 0, 32767, 1, qrs_pkg::ST_NONE, 0, 0);
        dir_rows[5]  = mk(1, 0, 0, 1, qrs_pkg::ST_ONE, 0, 0);
        dir_rows[6]  = mk(1, -2, 1, 1, qrs_pkg::ST_ONE, 65536, 65536);
        dir_rows[7]  = mk(1, 0, -1, 1, qrs_pkg::ST_TWO, 65536, -65536);
        dir_rows[8]  = mk(-1, 0, 1, 1, qrs_pkg::ST_TWO, -65536, 65536);
        dir_rows[9]  = mk(1, -32768, 0, 0, 0, 0, 0);
        dir_rows[10] = mk(1, 32767, -32768, 0, 0, 0, 0);
        dir_rows[11] = mk(-32768, -32768, 32767, 0, 0, 0, 0);
        dir_rows[12] = mk(-32768, 32767, 32767, 0, 0, 0, 0);
        dir_rows[13] = mk(32767, -32768, -32768, 0, 0, 0, 0);
        dir_rows[14] = mk(-32768, 0, -32768, 0, 0, 0, 0);
        dir_rows[15] = mk(1, 0, -2, 0, 0, 0, 0);
        dir_rows[16] = mk(3, 7, -5, 0, 0, 0, 0);
        dir_rows[17] = mk(-7, 3, 11, 0, 0, 0, 0);
        dir_rows[18] = mk(16384, -32768, 16384, 0, 0, 0, 0);
        dir_rows[19] = mk(-1, -32768, -32768, 0, 0, 0, 0);
    end

    task automatic send_coefs(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic signed [15:0] c, input bit known,
                              input t_roots res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_roots.push_back(known ? res : solve_roots(a, b, c));
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(3))
            0: return 16'($urandom_range(15)) - 16'd7;
            1: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver idling, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_roots e;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out++;
            if (expected_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected root beat");
            end else begin
                e = expected_roots.pop_front();
                n_status[e.status]++;
                if (o_root_status !== e.status || o_root_plus !== e.plus ||
                    o_root_minus !== e.minus) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 e.status, e.plus, e.minus,
                                 o_root_status, o_root_plus, o_root_minus);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int phase;
        int n;
        int wait_cnt;
        t_roots none;
        none = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < NDIR; i++)
            send_coefs(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
                       dir_rows[i].known, dir_rows[i].res);
        // long output hold-off while input keeps flowing
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_idle_pct = 0;
                for (int i = 0; i < 100; i++)
                    send_coefs(rand_coef(), rand_coef(), rand_coef(), 1'b0, none);
            end
        join
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 15 : 0;
            for (n = 0; n < (NRAND - 100) / 3; n++)
                send_coefs(rand_coef(), rand_coef(), rand_coef(), 1'b0, none);
        end
        i_valid <= 1'b0;
        wait_cnt = 0;
        while (expected_roots.size() != 0 && wait_cnt < 100000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (LAT) @(negedge i_clk);
        $display("%0d root beats checked: %0d none, %0d one, %0d two, %0d a-zero",
                 beats_out, n_status[0], n_status[1], n_status[2], n_status[3]);
        if (mismatches == 0 && expected_roots.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d beats missing", mismatches,
                     expected_roots.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/qrs_pkg.sv
rtl/qrs_fifo.sv
rtl/qrs_front.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver.sv
verif/tb_quadratic_root_solver.sv
